@@ hdl/warmer_thermostat_alarm_controller_unit_assert.svh @@
// Assertion macros for the warmer thermostat and alarm controller.
`ifndef WARMER_THERMOSTAT_ALARM_CONTROLLER_UNIT_ASSERT_SVH
`define WARMER_THERMOSTAT_ALARM_CONTROLLER_UNIT_ASSERT_SVH

// Same-cycle implication, checked at every rising edge outside reset.
`define WTAC_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define WTAC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ hdl/wtac_pkg.sv @@
// Types and constants of the warmer thermostat and alarm controller.
`default_nettype none

package wtac_pkg;

    localparam int SP_W     = 13;
    localparam int OFS_W    = 8;
    localparam int SIL_W    = 10;
    localparam int DIV_W    = 8;
    localparam int CFG_IX_W = 3;
    localparam int CFG_D_W  = 13;
    localparam int BTN_N    = 4;

    localparam logic [SP_W-1:0] SET_MAX = 13'd6000;

    // register reset values
    localparam logic [SP_W-1:0]  PREHEAT_LIMIT_RST  = 13'd3000;
    localparam logic [SP_W-1:0]  INIT_SET_POINT_RST = 13'd3050;
    localparam logic [SP_W-1:0]  AIR_LIMIT_RST      = 13'd3700;
    localparam logic [OFS_W-1:0] HEAT_OFF_OFS_RST   = 8'd10;
    localparam logic [OFS_W-1:0] HEAT_ON_OFS_RST    = 8'd20;
    localparam logic [OFS_W-1:0] ALARM_OFS_RST      = 8'd20;
    localparam logic [SIL_W-1:0] SILENCE_TICKS_RST  = 10'd600;
    localparam logic [DIV_W-1:0] UPDATE_DIV_RST     = 8'd2;

    typedef enum logic [CFG_IX_W-1:0] {
        CFG_PREHEAT_LIMIT     = 3'd0,
        CFG_INITIAL_SET_POINT = 3'd1,
        CFG_AIR_ALARM_LIMIT   = 3'd2,
        CFG_HEATER_OFF_OFFSET = 3'd3,
        CFG_HEATER_ON_OFFSET  = 3'd4,
        CFG_ALARM_OFFSET      = 3'd5,
        CFG_SILENCE_TICKS     = 3'd6,
        CFG_UPDATE_DIVIDE     = 3'd7
    } cfg_index_t;

    typedef enum logic [1:0] {
        CHIRP_NONE    = 2'd0,
        CHIRP_CONFIRM = 2'd1,
        CHIRP_PREHEAT = 2'd2
    } chirp_t;

    // button bit positions in the held mask
    localparam int BTN_STOP = 0;
    localparam int BTN_UP   = 1;
    localparam int BTN_DOWN = 2;
    localparam int BTN_MODE = 3;

endpackage

`default_nettype wire

@@ hdl/warmer_thermostat_alarm_controller_unit.sv @@
// Warmer thermostat and alarm controller: one control pass per input word.
//
//  channel  | signals                                   | direction
//  ---------+-------------------------------------------+----------
//  input    | in_valid/in_ready, tick .. mode_button     | in
//  result   | out_valid/out_ready, heater_on .. blink    | out
//  config   | cfg_write, cfg_index, cfg_data             | in
//
// One word per cycle while no held result stalls the input: each pass is
// computed from the input ports and the control state and lands in the result register.
// The result is valid in the cycle after the input is accepted.
// in_ready drops only while a result is held and out_ready is low.
// rst_n resets control state, configuration and out_valid at once; set point and edit value load 30.50.
`default_nettype none

module warmer_thermostat_alarm_controller_unit #(
    parameter int SET_STEP   = 10,
    parameter int TEMP_WIDTH = 18
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                in_valid,
    output logic                                     in_ready,
    input  wire logic                                tick,
    input  wire logic signed [TEMP_WIDTH-1:0]        skin_temp,
    input  wire logic signed [TEMP_WIDTH-1:0]        air_temp,
    input  wire logic                                stop_button,
    input  wire logic                                up_button,
    input  wire logic                                down_button,
    input  wire logic                                mode_button,
    output logic                                     out_valid,
    input  wire logic                                out_ready,
    output logic                                     heater_on,
    output logic                                     buzzer_on,
    output logic                                     skin_high_led,
    output logic                                     air_high_led,
    output logic                                     editing,
    output logic [wtac_pkg::SP_W-1:0]                active_set_point,
    output logic [wtac_pkg::SP_W-1:0]                pending_set_point,
    output logic                                     preheat_finished,
    output logic [1:0]                               chirp,
    output logic                                     blink_show,
    input  wire logic                                cfg_write,
    input  wire logic [wtac_pkg::CFG_IX_W-1:0]       cfg_index,
    input  wire logic [wtac_pkg::CFG_D_W-1:0]        cfg_data
);

    localparam int SP_W  = wtac_pkg::SP_W;
    localparam int OFS_W = wtac_pkg::OFS_W;
    localparam int SIL_W = wtac_pkg::SIL_W;
    localparam int DIV_W = wtac_pkg::DIV_W;
    // compare width: holds any reading and set point plus offset
    localparam int CW = ((TEMP_WIDTH > SP_W + 2) ? TEMP_WIDTH : SP_W + 2) + 1;
    localparam logic [SP_W:0]   STEP_EXT = (SP_W + 1)'(SET_STEP);
    localparam logic [SP_W-1:0] STEP_SP  = SP_W'(SET_STEP);

    // configuration
    logic [SP_W-1:0]  preheat_limit_reg;
    logic [SP_W-1:0]  air_alarm_limit_reg;
    logic [OFS_W-1:0] heater_off_offset_reg;
    logic [OFS_W-1:0] heater_on_offset_reg;
    logic [OFS_W-1:0] alarm_offset_reg;
    logic [SIL_W-1:0] silence_ticks_reg;
    logic [DIV_W-1:0] update_divide_reg;

    // control state
    logic                         preheat_over_reg,   preheat_over_next;
    logic                         heater_state_reg,   heater_state_next;
    logic                         buzzer_state_reg,   buzzer_state_next;
    logic                         alarm_active_reg,   alarm_active_next;
    logic                         silenced_reg,       silenced_next;
    logic [SIL_W-1:0]             silence_count_reg,  silence_count_next;
    logic [DIV_W-1:0]             tick_divider_reg,   tick_divider_next;
    logic                         update_pending_reg, update_pending_next;
    logic                         stop_requested_reg, stop_requested_next;
    logic [wtac_pkg::BTN_N-1:0]   button_held_reg,    button_held_next;
    logic                         edit_mode_reg,      edit_mode_next;
    logic [SP_W-1:0]              set_point_reg,      set_point_next;
    logic [SP_W-1:0]              edit_value_reg,     edit_value_next;
    logic signed [TEMP_WIDTH-1:0] skin_latched_reg,   skin_latched_next;
    logic signed [TEMP_WIDTH-1:0] air_latched_reg,    air_latched_next;
    logic                         buzz_phase_reg,     buzz_phase_next;
    logic                         blink_phase_reg,    blink_phase_next;

    // pass results
    logic             skin_led_next;
    logic             air_led_next;
    wtac_pkg::chirp_t chirp_next;

    // result register
    logic             out_valid_reg;
    logic             out_heater_reg;
    logic             out_buzzer_reg;
    logic             out_skin_led_reg;
    logic             out_air_led_reg;
    logic             out_editing_reg;
    logic [SP_W-1:0]  out_active_sp_reg;
    logic [SP_W-1:0]  out_pending_sp_reg;
    logic             out_preheat_reg;
    wtac_pkg::chirp_t out_chirp_reg;
    logic             out_blink_reg;

    logic in_fire;

    assign in_ready = !out_valid_reg || out_ready;
    assign in_fire  = in_valid && in_ready;

    // configuration writes; initial set point only matters at reset, and
    // reset restores its default, so it needs no storage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            preheat_limit_reg     <= wtac_pkg::PREHEAT_LIMIT_RST;
            air_alarm_limit_reg   <= wtac_pkg::AIR_LIMIT_RST;
            heater_off_offset_reg <= wtac_pkg::HEAT_OFF_OFS_RST;
            heater_on_offset_reg  <= wtac_pkg::HEAT_ON_OFS_RST;
            alarm_offset_reg      <= wtac_pkg::ALARM_OFS_RST;
            silence_ticks_reg     <= wtac_pkg::SILENCE_TICKS_RST;
            update_divide_reg     <= wtac_pkg::UPDATE_DIV_RST;
        end
        else if (cfg_write)
        begin
            unique case (wtac_pkg::cfg_index_t'(cfg_index))
                wtac_pkg::CFG_PREHEAT_LIMIT:     preheat_limit_reg     <= cfg_data;
                wtac_pkg::CFG_INITIAL_SET_POINT: ;
                wtac_pkg::CFG_AIR_ALARM_LIMIT:   air_alarm_limit_reg   <= cfg_data;
                wtac_pkg::CFG_HEATER_OFF_OFFSET: heater_off_offset_reg <= cfg_data[OFS_W-1:0];
                wtac_pkg::CFG_HEATER_ON_OFFSET:  heater_on_offset_reg  <= cfg_data[OFS_W-1:0];
                wtac_pkg::CFG_ALARM_OFFSET:      alarm_offset_reg      <= cfg_data[OFS_W-1:0];
                wtac_pkg::CFG_SILENCE_TICKS:     silence_ticks_reg     <= cfg_data[SIL_W-1:0];
                wtac_pkg::CFG_UPDATE_DIVIDE:     update_divide_reg     <= cfg_data[DIV_W-1:0];
                default: ;
            endcase
        end
    end

    // one control pass
    always_comb
    begin
        logic [DIV_W:0]          div_inc;
        logic signed [CW-1:0]    skin_w;
        logic signed [CW-1:0]    air_w;
        logic signed [CW-1:0]    sp_w;
        logic signed [CW-1:0]    lim_w;
        logic [SP_W:0]           ev_up;
        logic                    e_stop;
        logic                    e_up;
        logic                    e_down;
        logic                    e_mode;

        preheat_over_next   = preheat_over_reg;
        heater_state_next   = heater_state_reg;
        buzzer_state_next   = buzzer_state_reg;
        alarm_active_next   = alarm_active_reg;
        silenced_next       = silenced_reg;
        silence_count_next  = silence_count_reg;
        tick_divider_next   = tick_divider_reg;
        update_pending_next = update_pending_reg;
        stop_requested_next = stop_requested_reg;
        button_held_next    = button_held_reg;
        edit_mode_next      = edit_mode_reg;
        set_point_next      = set_point_reg;
        edit_value_next     = edit_value_reg;
        skin_latched_next   = skin_latched_reg;
        air_latched_next    = air_latched_reg;
        buzz_phase_next     = buzz_phase_reg;
        blink_phase_next    = blink_phase_reg;
        skin_led_next       = 1'b0;
        air_led_next        = 1'b0;
        chirp_next          = wtac_pkg::CHIRP_NONE;
        div_inc             = '0;
        skin_w              = '0;
        air_w               = '0;
        sp_w                = '0;
        lim_w               = '0;
        ev_up               = '0;
        e_stop              = 1'b0;
        e_up                = 1'b0;
        e_down              = 1'b0;
        e_mode              = 1'b0;

        if (tick)
        begin
            if (silenced_reg && silence_count_reg != {SIL_W{1'b1}})
                silence_count_next = silence_count_reg + 1'b1;
            div_inc = {1'b0, tick_divider_reg} + 1'b1;
            // a divide of zero is met at once, same as one
            if (div_inc >= {1'b0, update_divide_reg})
            begin
                update_pending_next = 1'b1;
                tick_divider_next   = '0;
            end
            else
                tick_divider_next = div_inc[DIV_W-1:0];
        end

        if (!preheat_over_reg)
        begin
            if (update_pending_next)
            begin
                update_pending_next = 1'b0;
                skin_latched_next   = skin_temp;
                skin_w = CW'(skin_temp);
                lim_w  = $signed(CW'(preheat_limit_reg));
                if (skin_w > lim_w)
                begin
                    heater_state_next = 1'b0;
                    preheat_over_next = 1'b1;
                    chirp_next        = wtac_pkg::CHIRP_PREHEAT;
                end
                else if (skin_w < lim_w)
                    heater_state_next = 1'b1;
            end
        end
        else
        begin
            skin_w = CW'(skin_latched_reg);
            lim_w  = $signed(CW'(set_point_reg)) + $signed(CW'(alarm_offset_reg));
            if (skin_w >= lim_w)
            begin
                if (!silenced_reg)
                    alarm_active_next = 1'b1;
                if (stop_requested_reg && !silenced_reg)
                begin
                    silenced_next       = 1'b1;
                    silence_count_next  = '0;
                    stop_requested_next = 1'b0;
                    alarm_active_next   = 1'b0;
                end
                skin_led_next = 1'b1;
            end
            else
            begin
                buzzer_state_next  = 1'b0;
                alarm_active_next  = 1'b0;
                silenced_next      = 1'b0;
                silence_count_next = '0;
            end
            if (silence_count_next >= silence_ticks_reg)
            begin
                silenced_next      = 1'b0;
                silence_count_next = '0;
            end
            air_w = CW'(air_latched_reg);
            air_led_next = air_w > $signed(CW'(air_alarm_limit_reg));

            // press edges; held mask follows the levels
            e_stop = stop_button && !button_held_reg[wtac_pkg::BTN_STOP];
            e_up   = up_button   && !button_held_reg[wtac_pkg::BTN_UP];
            e_down = down_button && !button_held_reg[wtac_pkg::BTN_DOWN];
            e_mode = mode_button && !button_held_reg[wtac_pkg::BTN_MODE];
            button_held_next = {mode_button, down_button, up_button, stop_button};

            if (e_stop)
            begin
                buzzer_state_next   = 1'b0;
                stop_requested_next = 1'b1;
            end
            if (e_up && edit_mode_reg)
            begin
                ev_up = {1'b0, edit_value_next} + STEP_EXT;
                if (ev_up >= {1'b0, wtac_pkg::SET_MAX})
                    edit_value_next = wtac_pkg::SET_MAX;
                else
                    edit_value_next = ev_up[SP_W-1:0];
            end
            if (e_down && edit_mode_reg)
            begin
                if (edit_value_next <= STEP_SP)
                    edit_value_next = '0;
                else
                    edit_value_next = edit_value_next - STEP_SP;
            end
            if (e_mode)
            begin
                edit_mode_next = !edit_mode_reg;
                if (edit_mode_reg)
                begin
                    set_point_next = edit_value_next;
                    chirp_next     = wtac_pkg::CHIRP_CONFIRM;
                end
            end

            if (update_pending_next)
            begin
                if (alarm_active_next)
                begin
                    buzz_phase_next   = !buzz_phase_reg;
                    buzzer_state_next = !buzz_phase_reg;
                end
                if (edit_mode_next)
                    blink_phase_next = !blink_phase_reg;
                skin_latched_next = skin_temp;
                air_latched_next  = air_temp;
                skin_w = CW'(skin_temp);
                sp_w   = $signed(CW'(set_point_next));
                if (skin_w >= sp_w - $signed(CW'(heater_off_offset_reg)))
                    heater_state_next = 1'b0;
                else if (skin_w <= sp_w - $signed(CW'(heater_on_offset_reg)))
                    heater_state_next = 1'b1;
                update_pending_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            preheat_over_reg   <= 1'b0;
            heater_state_reg   <= 1'b0;
            buzzer_state_reg   <= 1'b0;
            alarm_active_reg   <= 1'b0;
            silenced_reg       <= 1'b0;
            silence_count_reg  <= '0;
            tick_divider_reg   <= '0;
            update_pending_reg <= 1'b0;
            stop_requested_reg <= 1'b0;
            button_held_reg    <= '0;
            edit_mode_reg      <= 1'b0;
            set_point_reg      <= wtac_pkg::INIT_SET_POINT_RST;
            edit_value_reg     <= wtac_pkg::INIT_SET_POINT_RST;
            skin_latched_reg   <= '0;
            air_latched_reg    <= '0;
            buzz_phase_reg     <= 1'b0;
            blink_phase_reg    <= 1'b0;
        end
        else if (in_fire)
        begin
            preheat_over_reg   <= preheat_over_next;
            heater_state_reg   <= heater_state_next;
            buzzer_state_reg   <= buzzer_state_next;
            alarm_active_reg   <= alarm_active_next;
            silenced_reg       <= silenced_next;
            silence_count_reg  <= silence_count_next;
            tick_divider_reg   <= tick_divider_next;
            update_pending_reg <= update_pending_next;
            stop_requested_reg <= stop_requested_next;
            button_held_reg    <= button_held_next;
            edit_mode_reg      <= edit_mode_next;
            set_point_reg      <= set_point_next;
            edit_value_reg     <= edit_value_next;
            skin_latched_reg   <= skin_latched_next;
            air_latched_reg    <= air_latched_next;
            buzz_phase_reg     <= buzz_phase_next;
            blink_phase_reg    <= blink_phase_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (in_ready)
            out_valid_reg <= in_valid;
    end

    // result word payload
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            out_heater_reg     <= heater_state_next;
            out_buzzer_reg     <= buzzer_state_next;
            out_skin_led_reg   <= skin_led_next;
            out_air_led_reg    <= air_led_next;
            out_editing_reg    <= edit_mode_next;
            out_active_sp_reg  <= set_point_next;
            out_pending_sp_reg <= edit_value_next;
            out_preheat_reg    <= preheat_over_next;
            out_chirp_reg      <= chirp_next;
            out_blink_reg      <= blink_phase_next;
        end
    end

    assign out_valid         = out_valid_reg;
    assign heater_on         = out_heater_reg;
    assign buzzer_on         = out_buzzer_reg;
    assign skin_high_led     = out_skin_led_reg;
    assign air_high_led      = out_air_led_reg;
    assign editing           = out_editing_reg;
    assign active_set_point  = out_active_sp_reg;
    assign pending_set_point = out_pending_sp_reg;
    assign preheat_finished  = out_preheat_reg;
    assign chirp             = out_chirp_reg;
    assign blink_show        = out_blink_reg;

`include "warmer_thermostat_alarm_controller_unit_assert.svh"

    `WTAC_ASSERT_NEXT(a_preheat_sticky, preheat_over_reg, preheat_over_reg,
        "preheat done flag cleared")
    `WTAC_ASSERT_NOW(a_alarm_not_silenced, 1'b1, !(alarm_active_reg && silenced_reg),
        "alarm active while silenced")
    `WTAC_ASSERT_NOW(a_edit_value_range, 1'b1, edit_value_reg <= wtac_pkg::SET_MAX,
        "edit value above maximum")
    `WTAC_ASSERT_NEXT(a_preheat_chirp, in_fire && !preheat_over_reg && preheat_over_next,
        out_valid && chirp == wtac_pkg::CHIRP_PREHEAT && !heater_on,
        "preheat end word missing its chirp")

endmodule

`default_nettype wire

@@ bench/tb.sv @@
// Self-checking bench for the warmer thermostat and alarm controller: directed and random passes.
module tb;

    localparam int SET_STEP    = 10;
    localparam int TEMP_W      = 18;
    localparam int STALL_LIMIT = 2000;
    localparam int SP_W        = wtac_pkg::SP_W;
    localparam int OFS_W       = wtac_pkg::OFS_W;
    localparam int SIL_W       = wtac_pkg::SIL_W;
    localparam int DIV_W       = wtac_pkg::DIV_W;
    localparam int BTN_N       = wtac_pkg::BTN_N;
    localparam int CFG_IX_W    = wtac_pkg::CFG_IX_W;
    localparam int CFG_D_W     = wtac_pkg::CFG_D_W;

    typedef struct {
        logic                     tick;
        logic signed [TEMP_W-1:0] skin;
        logic signed [TEMP_W-1:0] air;
        logic                     stop;
        logic                     up;
        logic                     down;
        logic                     mode;
    } pass_in_t;

    typedef struct {
        logic             heater;
        logic             buzzer;
        logic             skin_led;
        logic             air_led;
        logic             editing;
        logic [SP_W-1:0]  active_sp;
        logic [SP_W-1:0]  pending_sp;
        logic             ph_done;
        wtac_pkg::chirp_t chirp;
        logic             blink;
    } pass_out_t;

    logic                     clk;
    logic                     rst_n;
    logic                     in_valid;
    logic                     in_ready;
    logic                     tick;
    logic signed [TEMP_W-1:0] skin_temp;
    logic signed [TEMP_W-1:0] air_temp;
    logic                     stop_button;
    logic                     up_button;
    logic                     down_button;
    logic                     mode_button;
    logic                     out_valid;
    logic                     out_ready;
    logic                     heater_on;
    logic                     buzzer_on;
    logic                     skin_high_led;
    logic                     air_high_led;
    logic                     editing;
    logic [SP_W-1:0]          active_set_point;
    logic [SP_W-1:0]          pending_set_point;
    logic                     preheat_finished;
    logic [1:0]               chirp;
    logic                     blink_show;
    logic                     cfg_write;
    logic [CFG_IX_W-1:0]      cfg_index;
    logic [CFG_D_W-1:0]       cfg_data;

    warmer_thermostat_alarm_controller_unit #(
        .SET_STEP   (SET_STEP),
        .TEMP_WIDTH (TEMP_W)
    ) u_dut (
        .clk               (clk),
        .rst_n             (rst_n),
        .in_valid          (in_valid),
        .in_ready          (in_ready),
        .tick              (tick),
        .skin_temp         (skin_temp),
        .air_temp          (air_temp),
        .stop_button       (stop_button),
        .up_button         (up_button),
        .down_button       (down_button),
        .mode_button       (mode_button),
        .out_valid         (out_valid),
        .out_ready         (out_ready),
        .heater_on         (heater_on),
        .buzzer_on         (buzzer_on),
        .skin_high_led     (skin_high_led),
        .air_high_led      (air_high_led),
        .editing           (editing),
        .active_set_point  (active_set_point),
        .pending_set_point (pending_set_point),
        .preheat_finished  (preheat_finished),
        .chirp             (chirp),
        .blink_show        (blink_show),
        .cfg_write         (cfg_write),
        .cfg_index         (cfg_index),
        .cfg_data          (cfg_data)
    );

    // register copies
    logic [SP_W-1:0]  cfg_preheat;
    logic [SP_W-1:0]  cfg_air;
    logic [OFS_W-1:0] cfg_heat_off;
    logic [OFS_W-1:0] cfg_heat_on;
    logic [OFS_W-1:0] cfg_alarm_ofs;
    logic [SIL_W-1:0] cfg_silence;
    logic [DIV_W-1:0] cfg_divide;

    // controller state as predicted
    logic             ph_done;
    logic             heat;
    logic             buzz;
    logic             alarm;
    logic             hushed;
    logic [SIL_W-1:0] hush_count;
    int               tick_div;
    logic             upd_due;
    logic             stop_req;
    logic [BTN_N-1:0] held;
    logic             edit_on;
    logic [SP_W-1:0]  sp_now;
    logic [SP_W-1:0]  sp_edit;
    int               skin_held;
    int               air_held;
    logic             buzz_ph;
    logic             blink_ph;

    pass_out_t expected_passes[$];
    int        error_count;
    int        idle_cycles;

    int   send_idle_pct;
    int   recv_stall_pct;
    int   tick_pct;
    logic lvl_stop;
    logic lvl_up;
    logic lvl_down;
    logic lvl_mode;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        out_ready = 1'b0;
        forever
        begin
            @(negedge clk);
            out_ready = ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // press edge on button bit b, keeps the held mask
    function automatic logic press_edge(int b, logic level);
        if (level && !held[b])
        begin
            held[b] = 1'b1;
            return 1'b1;
        end
        if (!level)
            held[b] = 1'b0;
        return 1'b0;
    endfunction

    function automatic pass_out_t thermostat_pass(pass_in_t w);
        pass_out_t        r;
        int               sp_start;
        int               sp_after;
        logic             skin_led;
        logic             air_led;
        wtac_pkg::chirp_t ch;
        ch       = wtac_pkg::CHIRP_NONE;
        skin_led = 1'b0;
        air_led  = 1'b0;
        sp_start = sp_now;
        if (w.tick)
        begin
            if (hushed && hush_count != '1)
                hush_count++;
            tick_div++;
            if (tick_div >= cfg_divide)
            begin
                upd_due  = 1'b1;
                tick_div = 0;
            end
        end
        if (!ph_done)
        begin
            if (upd_due)
            begin
                upd_due   = 1'b0;
                skin_held = w.skin;
                if (skin_held > int'(cfg_preheat))
                begin
                    heat    = 1'b0;
                    ph_done = 1'b1;
                    ch      = wtac_pkg::CHIRP_PREHEAT;
                end
                else if (skin_held < int'(cfg_preheat))
                    heat = 1'b1;
            end
        end
        else
        begin
            if (skin_held >= sp_start + int'(cfg_alarm_ofs))
            begin
                if (!hushed)
                    alarm = 1'b1;
                if (stop_req && !hushed)
                begin
                    hushed     = 1'b1;
                    hush_count = '0;
                    stop_req   = 1'b0;
                    alarm      = 1'b0;
                end
                skin_led = 1'b1;
            end
            else
            begin
                buzz       = 1'b0;
                alarm      = 1'b0;
                hushed     = 1'b0;
                hush_count = '0;
            end
            if (hush_count >= cfg_silence)
            begin
                hushed     = 1'b0;
                hush_count = '0;
            end
            air_led = air_held > int'(cfg_air);

            if (press_edge(wtac_pkg::BTN_STOP, w.stop))
            begin
                buzz     = 1'b0;
                stop_req = 1'b1;
            end
            if (press_edge(wtac_pkg::BTN_UP, w.up) && edit_on)
                sp_edit = (int'(sp_edit) + SET_STEP >= int'(wtac_pkg::SET_MAX))
                          ? wtac_pkg::SET_MAX : SP_W'(int'(sp_edit) + SET_STEP);
            if (press_edge(wtac_pkg::BTN_DOWN, w.down) && edit_on)
                sp_edit = (int'(sp_edit) <= SET_STEP) ? '0 : SP_W'(int'(sp_edit) - SET_STEP);
            if (press_edge(wtac_pkg::BTN_MODE, w.mode))
            begin
                edit_on = !edit_on;
                if (!edit_on)
                begin
                    sp_now = sp_edit;
                    ch     = wtac_pkg::CHIRP_CONFIRM;
                end
            end

            if (upd_due)
            begin
                // hysteresis uses the set point after this pass's buttons
                sp_after = sp_now;
                if (alarm)
                begin
                    buzz_ph = !buzz_ph;
                    buzz    = buzz_ph;
                end
                if (edit_on)
                    blink_ph = !blink_ph;
                skin_held = w.skin;
                air_held  = w.air;
                if (skin_held >= sp_after - int'(cfg_heat_off))
                    heat = 1'b0;
                else if (skin_held <= sp_after - int'(cfg_heat_on))
                    heat = 1'b1;
                upd_due = 1'b0;
            end
        end
        r.heater     = heat;
        r.buzzer     = buzz;
        r.skin_led   = skin_led;
        r.air_led    = air_led;
        r.editing    = edit_on;
        r.active_sp  = sp_now;
        r.pending_sp = sp_edit;
        r.ph_done    = ph_done;
        r.chirp      = ch;
        r.blink      = blink_ph;
        return r;
    endfunction

    task automatic compare_field(string name, logic [SP_W-1:0] want, logic [SP_W-1:0] got);
        if (got !== want)
        begin
            $display("%0t %s: expected %0d, got %0d", $time, name, want, got);
            error_count++;
        end
    endtask

    always @(posedge clk)
    begin : result_monitor
        pass_in_t  seen;
        pass_out_t want;
        logic      moved;
        if (rst_n)
        begin
            moved = (in_valid && in_ready) || (out_valid && out_ready);
            if (out_valid && out_ready)
            begin
                if (expected_passes.size() == 0)
                begin
                    $display("%0t result word with nothing pending", $time);
                    error_count++;
                end
                else
                begin
                    want = expected_passes.pop_front();
                    compare_field("heater_on", SP_W'(want.heater), SP_W'(heater_on));
                    compare_field("buzzer_on", SP_W'(want.buzzer), SP_W'(buzzer_on));
                    compare_field("skin_high_led", SP_W'(want.skin_led),
                                  SP_W'(skin_high_led));
                    compare_field("air_high_led", SP_W'(want.air_led), SP_W'(air_high_led));
                    compare_field("editing", SP_W'(want.editing), SP_W'(editing));
                    compare_field("active_set_point", want.active_sp, active_set_point);
                    compare_field("pending_set_point", want.pending_sp, pending_set_point);
                    compare_field("preheat_finished", SP_W'(want.ph_done),
                                  SP_W'(preheat_finished));
                    compare_field("chirp", SP_W'(want.chirp), SP_W'(chirp));
                    compare_field("blink_show", SP_W'(want.blink), SP_W'(blink_show));
                end
            end
            if (in_valid && in_ready)
            begin
                seen.tick = tick;
                seen.skin = skin_temp;
                seen.air  = air_temp;
                seen.stop = stop_button;
                seen.up   = up_button;
                seen.down = down_button;
                seen.mode = mode_button;
                expected_passes.push_back(thermostat_pass(seen));
            end
            idle_cycles = moved ? 0 : idle_cycles + 1;
            if (idle_cycles >= STALL_LIMIT)
            begin
                $display("%0t no word moved for %0d cycles", $time, STALL_LIMIT);
                $display("Testbench completed WITH ERRORS");
                $finish;
            end
        end
    end

    // called at a falling edge; returns at the falling edge after acceptance
    task automatic send_word(pass_in_t w);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid = 1'b0;
            @(negedge clk);
        end
        tick        = w.tick;
        skin_temp   = w.skin;
        air_temp    = w.air;
        stop_button = w.stop;
        up_button   = w.up;
        down_button = w.down;
        mode_button = w.mode;
        in_valid    = 1'b1;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        @(negedge clk);
    endtask

    function automatic pass_in_t word_of(logic t, int skin, int air,
                                         logic s, logic u, logic d, logic m);
        pass_in_t w;
        w.tick = t;
        w.skin = TEMP_W'(skin);
        w.air  = TEMP_W'(air);
        w.stop = s;
        w.up   = u;
        w.down = d;
        w.mode = m;
        return w;
    endfunction

    // random temperatures clustered on the thresholds, buttons from held levels
    function automatic pass_in_t compose_word();
        pass_in_t w;
        int       pick;
        int       sp;
        sp     = sp_now;
        pick   = $urandom_range(99);
        w.tick = ($urandom_range(99) < tick_pct);
        if (pick < 45)
            w.skin = TEMP_W'(sp + int'($urandom_range(600)) - 300);
        else if (pick < 65)
            w.skin = TEMP_W'(sp + int'(cfg_alarm_ofs) + int'($urandom_range(6)) - 3);
        else if (pick < 85)
            w.skin = TEMP_W'(sp - int'(pick[0] ? cfg_heat_off : cfg_heat_on)
                             + int'($urandom_range(4)) - 2);
        else
            w.skin = TEMP_W'(int'($urandom_range(105000)) - 20000);
        if ($urandom_range(1))
            w.air = TEMP_W'(int'(cfg_air) + int'($urandom_range(4)) - 2);
        else
            w.air = TEMP_W'(int'($urandom_range(105000)) - 20000);
        w.stop = lvl_stop;
        w.up   = lvl_up;
        w.down = lvl_down;
        w.mode = lvl_mode;
        return w;
    endfunction

    task automatic write_reg(wtac_pkg::cfg_index_t ix, int value);
        cfg_write = 1'b1;
        cfg_index = ix;
        cfg_data  = value[CFG_D_W-1:0];
        @(negedge clk);
        cfg_write = 1'b0;
        case (ix)
            wtac_pkg::CFG_PREHEAT_LIMIT:     cfg_preheat   = SP_W'(value);
            // only acts at reset, which restores its default
            wtac_pkg::CFG_INITIAL_SET_POINT: ;
            wtac_pkg::CFG_AIR_ALARM_LIMIT:   cfg_air       = SP_W'(value);
            wtac_pkg::CFG_HEATER_OFF_OFFSET: cfg_heat_off  = OFS_W'(value);
            wtac_pkg::CFG_HEATER_ON_OFFSET:  cfg_heat_on   = OFS_W'(value);
            wtac_pkg::CFG_ALARM_OFFSET:      cfg_alarm_ofs = OFS_W'(value);
            wtac_pkg::CFG_SILENCE_TICKS:     cfg_silence   = SIL_W'(value);
            wtac_pkg::CFG_UPDATE_DIVIDE:     cfg_divide    = DIV_W'(value);
            default: ;
        endcase
    endtask

    // wait until every pending result is out before touching registers
    task automatic settle();
        in_valid = 1'b0;
        while (expected_passes.size() != 0)
            @(negedge clk);
        repeat (2) @(negedge clk);
    endtask

    task automatic set_controls(int air, int heat_off, int heat_on,
                                int alarm_ofs, int silence, int divide);
        settle();
        write_reg(wtac_pkg::CFG_AIR_ALARM_LIMIT, air);
        write_reg(wtac_pkg::CFG_HEATER_OFF_OFFSET, heat_off);
        write_reg(wtac_pkg::CFG_HEATER_ON_OFFSET, heat_on);
        write_reg(wtac_pkg::CFG_ALARM_OFFSET, alarm_ofs);
        write_reg(wtac_pkg::CFG_SILENCE_TICKS, silence);
        write_reg(wtac_pkg::CFG_UPDATE_DIVIDE, divide);
    endtask

    task automatic test_preheat();
        write_reg(wtac_pkg::CFG_PREHEAT_LIMIT, 6000);
        write_reg(wtac_pkg::CFG_UPDATE_DIVIDE, 1);
        // buttons are ignored during preheat
        send_word(word_of(1'b0, 6000, 0, 1'b1, 1'b1, 1'b1, 1'b1));
        send_word(word_of(1'b1, 6000, 0, 1'b0, 1'b0, 1'b0, 1'b0));
        send_word(word_of(1'b1, -20000, 0, 1'b0, 1'b0, 1'b0, 1'b0));
        send_word(word_of(1'b1, 6000, 0, 1'b0, 1'b0, 1'b0, 1'b0));
        settle();
        write_reg(wtac_pkg::CFG_PREHEAT_LIMIT, 0);
        // stop and mode held through the end of preheat, seen as edges next word
        send_word(word_of(1'b1, 85000, 85000, 1'b1, 1'b0, 1'b0, 1'b1));
    endtask

    task automatic test_set_point_edit();
        send_word(word_of(1'b1, 3000, 3000, 1'b1, 1'b0, 1'b0, 1'b1));
        send_word(word_of(1'b1, 3000, 3000, 1'b0, 1'b1, 1'b0, 1'b1));
        send_word(word_of(1'b1, 3000, 3000, 1'b0, 1'b0, 1'b0, 1'b0));
        send_word(word_of(1'b1, 3000, 3000, 1'b0, 1'b0, 1'b1, 1'b0));
        send_word(word_of(1'b1, 3000, 3000, 1'b0, 1'b1, 1'b0, 1'b0));
        send_word(word_of(1'b0, 3000, 3000, 1'b0, 1'b1, 1'b0, 1'b1));
        send_word(word_of(1'b0, 3000, 3000, 1'b0, 1'b0, 1'b0, 1'b0));
        // not editing: up edge is dropped
        send_word(word_of(1'b0, 3000, 3000, 1'b0, 1'b1, 1'b0, 1'b0));
    endtask

    task automatic test_alarm_and_silence();
        settle();
        write_reg(wtac_pkg::CFG_SILENCE_TICKS, 0);
        write_reg(wtac_pkg::CFG_UPDATE_DIVIDE, 0);
        send_word(word_of(1'b1, 6000, 85000, 1'b0, 1'b0, 1'b0, 1'b0));
        send_word(word_of(1'b0, 6000, 85000, 1'b0, 1'b0, 1'b0, 1'b0));
        send_word(word_of(1'b1, 6000, 85000, 1'b0, 1'b0, 1'b0, 1'b0));
        send_word(word_of(1'b1, 6000, 85000, 1'b0, 1'b0, 1'b0, 1'b0));
        send_word(word_of(1'b1, 6000, 85000, 1'b0, 1'b0, 1'b0, 1'b0));
        settle();
        write_reg(wtac_pkg::CFG_SILENCE_TICKS, 2);
        write_reg(wtac_pkg::CFG_UPDATE_DIVIDE, 1);
        send_word(word_of(1'b0, 6000, 85000, 1'b1, 1'b0, 1'b0, 1'b0));
        send_word(word_of(1'b0, 6000, 85000, 1'b0, 1'b0, 1'b0, 1'b0));
        send_word(word_of(1'b1, 6000, 85000, 1'b0, 1'b0, 1'b0, 1'b0));
        send_word(word_of(1'b1, 6000, 85000, 1'b0, 1'b0, 1'b0, 1'b0));
        send_word(word_of(1'b1, 6000, 85000, 1'b0, 1'b0, 1'b0, 1'b0));
        send_word(word_of(1'b1, 0, -20000, 1'b0, 1'b0, 1'b0, 1'b0));
        send_word(word_of(1'b0, 0, -20000, 1'b0, 1'b0, 1'b0, 1'b0));
    endtask

    task automatic test_control_traffic(int count);
        for (int n = 0; n < count; n++)
        begin
            if ($urandom_range(99) < 15)
                lvl_stop = !lvl_stop;
            if ($urandom_range(99) < 35)
                lvl_up = !lvl_up;
            if ($urandom_range(99) < 35)
                lvl_down = !lvl_down;
            if ($urandom_range(99) < 8)
                lvl_mode = !lvl_mode;
            send_word(compose_word());
        end
    endtask

    // walk the edited value to target by single steps, then commit it
    task automatic test_set_point_sweep(int target);
        lvl_up   = 1'b0;
        lvl_down = 1'b0;
        lvl_mode = 1'b0;
        send_word(compose_word());
        if (!edit_on)
        begin
            lvl_mode = 1'b1;
            send_word(compose_word());
            lvl_mode = 1'b0;
            send_word(compose_word());
        end
        while (int'(sp_edit) != target)
        begin
            lvl_up   = (int'(sp_edit) < target);
            lvl_down = !lvl_up;
            send_word(compose_word());
            lvl_up   = 1'b0;
            lvl_down = 1'b0;
            if ($urandom_range(99) < 10)
                lvl_stop = !lvl_stop;
            send_word(compose_word());
        end
        lvl_mode = 1'b1;
        send_word(compose_word());
        lvl_mode = 1'b0;
        send_word(compose_word());
    endtask

    initial
    begin
        rst_n          = 1'b0;
        in_valid       = 1'b0;
        tick           = 1'b0;
        skin_temp      = '0;
        air_temp       = '0;
        stop_button    = 1'b0;
        up_button      = 1'b0;
        down_button    = 1'b0;
        mode_button    = 1'b0;
        cfg_write      = 1'b0;
        cfg_index      = wtac_pkg::CFG_PREHEAT_LIMIT;
        cfg_data       = '0;
        error_count    = 0;
        idle_cycles    = 0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        tick_pct       = 50;
        lvl_stop       = 1'b0;
        lvl_up         = 1'b0;
        lvl_down       = 1'b0;
        lvl_mode       = 1'b0;

        cfg_preheat   = wtac_pkg::PREHEAT_LIMIT_RST;
        cfg_air       = wtac_pkg::AIR_LIMIT_RST;
        cfg_heat_off  = wtac_pkg::HEAT_OFF_OFS_RST;
        cfg_heat_on   = wtac_pkg::HEAT_ON_OFS_RST;
        cfg_alarm_ofs = wtac_pkg::ALARM_OFS_RST;
        cfg_silence   = wtac_pkg::SILENCE_TICKS_RST;
        cfg_divide    = wtac_pkg::UPDATE_DIV_RST;
        ph_done       = 1'b0;
        heat          = 1'b0;
        buzz          = 1'b0;
        alarm         = 1'b0;
        hushed        = 1'b0;
        hush_count    = '0;
        tick_div      = 0;
        upd_due       = 1'b0;
        stop_req      = 1'b0;
        held          = '0;
        edit_on       = 1'b0;
        sp_now        = wtac_pkg::INIT_SET_POINT_RST;
        sp_edit       = wtac_pkg::INIT_SET_POINT_RST;
        skin_held     = 0;
        air_held      = 0;
        buzz_ph       = 1'b0;
        blink_ph      = 1'b0;

        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_preheat();
        test_set_point_edit();
        test_alarm_and_silence();

        set_controls(3700, 10, 20, 20, 600, 2);
        test_control_traffic(120);
        test_set_point_sweep(int'(wtac_pkg::SET_MAX));

        set_controls(0, 0, 0, 0, 1, 1);
        write_reg(wtac_pkg::CFG_INITIAL_SET_POINT, 0);
        send_idle_pct = 73;
        test_control_traffic(120);
        test_set_point_sweep(int'(wtac_pkg::SET_MAX) - 100);

        // slowest divider, with ticks present on most words
        set_controls(6000, 255, 255, 255, 1023, 255);
        write_reg(wtac_pkg::CFG_INITIAL_SET_POINT, 6000);
        send_idle_pct  = 0;
        recv_stall_pct = 73;
        tick_pct       = 90;
        test_control_traffic(120);
        test_set_point_sweep(int'(wtac_pkg::SET_MAX) - 200);

        set_controls($urandom_range(6000), $urandom_range(255), $urandom_range(255),
                     $urandom_range(255), $urandom_range(1, 1023), $urandom_range(1, 8));
        write_reg(wtac_pkg::CFG_PREHEAT_LIMIT, $urandom_range(6000));
        write_reg(wtac_pkg::CFG_INITIAL_SET_POINT, $urandom_range(6000));
        send_idle_pct  = 22;
        recv_stall_pct = 22;
        tick_pct       = 50;
        test_control_traffic(120);

        in_valid = 1'b0;
        while (expected_passes.size() != 0)
            @(posedge clk);
        repeat (5) @(posedge clk);
        if (error_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
